>>> rtl/tps_pkg.sv
// Shared types and codes for the tone pattern sequencer.
`default_nettype none

package tps_pkg;

  // Field widths of the request and response transactions
  localparam int REQ_W  = 2;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;
  localparam int TIME_W = 16;
  localparam int POS_W  = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [CNT_W-1:0]  note_count;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
  } req_t;

  typedef struct packed {
    logic             buzzer_drive;
    logic             playing;
    logic [POS_W-1:0] note_position;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/tps_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module tps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tps_ctrl.sv
// Playback state, current note cache and per-transaction update logic.
`default_nettype none

module tps_ctrl #(
  parameter int NOTE_DEPTH    = 32,
  parameter int DURATION_BITS = 16,
  localparam int AW = $clog2(NOTE_DEPTH),
  localparam int DW = DURATION_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire tps_pkg::req_t   item,
  input  wire logic [AW-1:0]   item_addr,
  input  wire logic [2*DW-1:0] rd_data,
  output logic      [AW-1:0]   next_addr,
  output tps_pkg::rsp_t        result
);

  localparam int LW = $clog2(NOTE_DEPTH + 1);
  localparam int CW = AW + 1;
  localparam int PW = tps_pkg::POS_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;

  logic [1:0]    phase, phase_next;
  logic [AW-1:0] base, base_next;
  logic [LW-1:0] length, length_next;
  logic [AW-1:0] offset, offset_next;
  logic [DW-1:0] elapsed, elapsed_next;
  logic [DW-1:0] cur_on, cur_on_next;
  logic [DW-1:0] cur_off, cur_off_next;

  logic [DW-1:0] rd_on, rd_off, elapsed_inc;
  logic [AW-1:0] cur_addr;
  logic [CW-1:0] offset_inc;
  logic          last_note;

  // Sum of base and offset wrapped into the store; the sum stays below twice the depth
  function automatic logic [AW-1:0] wrap_sum(input logic [CW-1:0] s);
    logic [CW-1:0] r;
    r = s;
    if (s >= CW'(NOTE_DEPTH)) begin
      r = s - CW'(NOTE_DEPTH);
    end
    return r[AW-1:0];
  endfunction

  assign rd_on       = rd_data[2*DW-1:DW];
  assign rd_off      = rd_data[DW-1:0];
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign cur_addr    = wrap_sum(CW'(base) + CW'(offset));
  assign offset_inc  = CW'(offset) + 1'b1;
  // Pattern ends at the count or at an all-zero next entry
  assign last_note   = (offset_inc >= CW'(length)) || (rd_data == '0);

  // Next state for the transaction in the compute stage
  always_comb begin
    phase_next   = phase;
    base_next    = base;
    length_next  = length;
    offset_next  = offset;
    elapsed_next = elapsed;
    cur_on_next  = cur_on;
    cur_off_next = cur_off;
    if (step) begin
      unique case (item.req_type)
        tps_pkg::REQ_TICK: begin
          if (phase == PH_ON) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= cur_on) begin
              phase_next   = PH_OFF;
              elapsed_next = '0;
            end
          end else if (phase == PH_OFF) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= cur_off) begin
              elapsed_next = '0;
              if (last_note) begin
                phase_next  = PH_IDLE;
                length_next = '0;
                offset_next = '0;
              end else begin
                phase_next   = PH_ON;
                offset_next  = offset_inc[AW-1:0];
                cur_on_next  = rd_on;
                cur_off_next = rd_off;
              end
            end
          end
        end
        tps_pkg::REQ_WRITE: begin
          // keep the cached note in step with the store
          if (item_addr == cur_addr) begin
            cur_on_next  = DW'(item.on_time);
            cur_off_next = DW'(item.off_time);
          end
        end
        tps_pkg::REQ_START: begin
          if (item.note_count != '0) begin
            base_next    = item_addr;
            length_next  = (int'(item.note_count) > NOTE_DEPTH) ?
                           LW'(NOTE_DEPTH) : LW'(item.note_count);
            offset_next  = '0;
            phase_next   = PH_ON;
            elapsed_next = '0;
            cur_on_next  = rd_on;
            cur_off_next = rd_off;
          end
        end
        tps_pkg::REQ_STOP: begin
          phase_next   = PH_IDLE;
          length_next  = '0;
          offset_next  = '0;
          elapsed_next = '0;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Entry after the current one, as seen by the following transaction
  assign next_addr = wrap_sum(CW'(base_next) + CW'(offset_next) + 1'b1);

  // Response shows the state after the transaction
  always_comb begin
    result.buzzer_drive  = (phase_next == PH_ON) && (cur_on_next != '0);
    result.playing       = (phase_next == PH_ON) || (phase_next == PH_OFF);
    result.note_position = PW'(offset_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      base    <= '0;
      length  <= '0;
      offset  <= '0;
      elapsed <= '0;
    end else begin
      phase   <= phase_next;
      base    <= base_next;
      length  <= length_next;
      offset  <= offset_next;
      elapsed <= elapsed_next;
    end
  end

  // Cached on and off time of the current note
  always_ff @(posedge clk) begin
    cur_on  <= cur_on_next;
    cur_off <= cur_off_next;
  end

endmodule

`default_nettype wire

>>> rtl/tone_pattern_sequencer.sv
// Top level of the tone pattern sequencer: request stage, note store and response register.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------
//  request | req_valid | req_ready | req (tps_pkg::req_t)
//  response| rsp_valid | rsp_ready | rsp (tps_pkg::rsp_t)
//
// One transaction per cycle while responses are taken; the note store read is issued as a
// request is taken, and the playback update runs on the registered read data when the
// request stage hands it to the response register; the cached current note covers the rest.
// Synchronous reset clears playback and handshake state; the note store is not cleared.
// A stalled response holds the request stage; one further request may still be taken.
`default_nettype none

module tone_pattern_sequencer #(
  parameter int NOTE_DEPTH    = 32,
  parameter int DURATION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tps_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tps_pkg::rsp_t      rsp
);

  localparam int AW         = $clog2(NOTE_DEPTH);
  localparam int DW         = DURATION_BITS;
  localparam int IW         = tps_pkg::IDX_W;
  localparam int WRAP_STEPS = 8;

  logic          req_fire, s1_fire;
  logic          s1_valid;
  tps_pkg::req_t s1_item;
  logic [AW-1:0] s1_addr;
  logic [AW-1:0] req_addr, rd_addr, next_addr;
  logic [IW-1:0] idx_wrap;
  logic [2*DW-1:0] rd_data;
  tps_pkg::rsp_t result;

  // Entry index wrapped into the store by repeated subtraction
  always_comb begin
    idx_wrap = req.entry_index;
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (int'(idx_wrap) >= NOTE_DEPTH) begin
        idx_wrap = idx_wrap - IW'(NOTE_DEPTH);
      end
    end
  end
  assign req_addr = AW'(idx_wrap);

  // Handshake
  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_fire;
  assign req_fire  = req_valid && req_ready;

  // Request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_item <= req;
      s1_addr <= req_addr;
    end
  end

  // Start reads its base entry; ticks and stops prefetch the next note, writes read nothing
  assign rd_addr = (req.req_type == tps_pkg::REQ_START) ? req_addr : next_addr;

  tps_ram #(
    .WIDTH (2 * DW),
    .DEPTH (NOTE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (req_fire && (req.req_type == tps_pkg::REQ_WRITE)),
    .wr_addr (req_addr),
    .wr_data ({DW'(req.on_time), DW'(req.off_time)}),
    .rd_en   (req_fire && (req.req_type != tps_pkg::REQ_WRITE)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tps_ctrl #(
    .NOTE_DEPTH    (NOTE_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .item      (s1_item),
    .item_addr (s1_addr),
    .rd_data   (rd_data),
    .next_addr (next_addr),
    .result    (result)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp <= result;
    end
  end

`ifndef SYNTHESIS
  // A taken request always lands in the request stage
  a_req_lands: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> s1_valid)
    else $error("request transaction lost");

  // A blocked request stage keeps its transaction
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_item) && $stable(s1_addr)))
    else $error("request stage changed while blocked");

  // The buzzer only sounds during playback
  a_drive_playing: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.buzzer_drive) |-> rsp.playing)
    else $error("buzzer driven while idle");

  // Position reads zero when idle
  a_idle_position: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.playing) |-> (rsp.note_position == '0))
    else $error("nonzero note position while idle");
`endif

endmodule

`default_nettype wire

>>> verif/tone_pattern_sequencer_tb.sv
// Testbench for the tone pattern sequencer: predicts every response and checks it field by field.
`timescale 1ns / 1ps

module tone_pattern_sequencer_tb;
  import tps_pkg::*;

  localparam int DEPTH        = 32;
  localparam int ITEMS_STAGE  = 410;
  localparam int MAX_PRINTS   = 50;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_ON   = 2'd1,
    PHASE_OFF  = 2'd2
  } play_phase_e;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Pacing controls; the idle and stall percentages change only at the falling edge
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic rsp_hold       = 1'b0;
  int   stage_no       = 0;
  int   mismatch_count = 0;

  req_t pending_req_q[$];
  rsp_t expected_rsp_q[$];
  rsp_t want;

  // Note contents as the stimulus will have written them (used to size tick runs)
  int planned_on_ms  [DEPTH];
  int planned_off_ms [DEPTH];

  // Predicted sequencer state, advanced on each accepted request
  logic [TIME_W-1:0] tone_on_ms  [DEPTH];
  logic [TIME_W-1:0] tone_off_ms [DEPTH];
  logic [IDX_W-1:0]  pat_base    = '0;
  logic [CNT_W-1:0]  pat_len     = '0;
  logic [POS_W-1:0]  pat_pos     = '0;
  play_phase_e       pat_phase   = PHASE_IDLE;
  logic [TIME_W-1:0] pat_elapsed = '0;

  tone_pattern_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Playback state after one request, and the response it shows
  function automatic rsp_t predict_playback(input req_t r);
    rsp_t             o;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    int               nxt_pos;
    case (r.req_type)
      REQ_TICK: begin
        if (pat_phase != PHASE_IDLE) begin
          if (pat_elapsed != '1) pat_elapsed = pat_elapsed + 1'b1;
          cur = pat_base + pat_pos;
          if (pat_phase == PHASE_ON) begin
            if (pat_elapsed >= tone_on_ms[cur]) begin
              pat_phase   = PHASE_OFF;
              pat_elapsed = '0;
            end
          end else if (pat_elapsed >= tone_off_ms[cur]) begin
            nxt_pos = int'(pat_pos) + 1;
            nxt     = pat_base + pat_pos + 1'b1;
            if (nxt_pos >= int'(pat_len) ||
                (tone_on_ms[nxt] == '0 && tone_off_ms[nxt] == '0)) begin
              pat_len     = '0;
              pat_pos     = '0;
              pat_phase   = PHASE_IDLE;
              pat_elapsed = '0;
            end else begin
              pat_pos     = pat_pos + 1'b1;
              pat_phase   = PHASE_ON;
              pat_elapsed = '0;
            end
          end
        end
      end
      REQ_WRITE: begin
        tone_on_ms[r.entry_index]  = r.on_time;
        tone_off_ms[r.entry_index] = r.off_time;
      end
      REQ_START: begin
        if (r.note_count != '0) begin
          pat_base    = r.entry_index;
          pat_len     = (r.note_count > DEPTH) ? CNT_W'(DEPTH) : r.note_count;
          pat_pos     = '0;
          pat_phase   = PHASE_ON;
          pat_elapsed = '0;
        end
      end
      default: begin
        pat_len     = '0;
        pat_pos     = '0;
        pat_phase   = PHASE_IDLE;
        pat_elapsed = '0;
      end
    endcase
    cur             = pat_base + pat_pos;
    o.playing       = (pat_phase != PHASE_IDLE);
    o.buzzer_drive  = (pat_phase == PHASE_ON) && (tone_on_ms[cur] != '0);
    o.note_position = pat_pos;
    return o;
  endfunction

  // Request builders; unused fields carry random values
  function automatic req_t rand_req();
    req_t r;
    r.req_type    = REQ_W'($urandom);
    r.entry_index = IDX_W'($urandom);
    r.note_count  = CNT_W'($urandom);
    r.on_time     = TIME_W'($urandom);
    r.off_time    = TIME_W'($urandom);
    return r;
  endfunction

  function automatic void push_tick();
    req_t r;
    r          = rand_req();
    r.req_type = REQ_TICK;
    pending_req_q.push_back(r);
  endfunction

  function automatic void push_stop();
    req_t r;
    r          = rand_req();
    r.req_type = REQ_STOP;
    pending_req_q.push_back(r);
  endfunction

  function automatic void push_start(input int idx, input int cnt);
    req_t r;
    r             = rand_req();
    r.req_type    = REQ_START;
    r.entry_index = IDX_W'(idx);
    r.note_count  = CNT_W'(cnt);
    pending_req_q.push_back(r);
  endfunction

  function automatic void push_write(input int idx, input int on_ms, input int off_ms);
    req_t r;
    r             = rand_req();
    r.req_type    = REQ_WRITE;
    r.entry_index = IDX_W'(idx);
    r.on_time     = TIME_W'(on_ms);
    r.off_time    = TIME_W'(off_ms);
    planned_on_ms[idx % DEPTH]  = on_ms;
    planned_off_ms[idx % DEPTH] = off_ms;
    pending_req_q.push_back(r);
  endfunction

  // Mostly whole patterns: write a window, start it, tick it through; the rest is noise
  task automatic random_items(input int target);
    int   n;
    int   pick;
    int   base;
    int   cnt;
    int   span;
    int   ticks;
    int   k;
    int   e;
    req_t r;
    n = 0;
    while (n < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        base = $urandom_range(DEPTH - 1);
        cnt  = ($urandom_range(9) == 0) ? $urandom_range(33, 63) : $urandom_range(1, 6);
        span = (cnt > 6) ? 8 : cnt;
        for (k = 0; k <= span; k++) begin
          if ($urandom_range(4) != 0) begin
            if (k > 0 && $urandom_range(9) == 0) begin
              push_write(base + k, 0, 0);
            end else begin
              push_write(base + k, $urandom_range(0, 4), $urandom_range(0, 4));
            end
            n++;
          end
        end
        push_start(base, cnt);
        n++;
        // ticks the whole pattern should take, given what will be in the store
        ticks = 0;
        for (k = 0; k < ((cnt > DEPTH) ? DEPTH : cnt); k++) begin
          e = (base + k) % DEPTH;
          if (k > 0 && planned_on_ms[e] == 0 && planned_off_ms[e] == 0) break;
          ticks += ((planned_on_ms[e] == 0) ? 1 : planned_on_ms[e]) +
                   ((planned_off_ms[e] == 0) ? 1 : planned_off_ms[e]);
        end
        if (ticks > 200) ticks = $urandom_range(1, 20);
        else if ($urandom_range(5) == 0) ticks = $urandom_range(0, ticks);
        else ticks += $urandom_range(0, 2);
        for (k = 0; k < ticks; k++) begin
          if ($urandom_range(19) == 0) begin
            push_write($urandom_range(DEPTH - 1), $urandom_range(0, 4), $urandom_range(0, 4));
          end else begin
            push_tick();
          end
          n++;
        end
        if ($urandom_range(3) == 0) begin
          push_stop();
          n++;
        end
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0:       push_stop();
          1:       push_start($urandom_range(DEPTH - 1), 0);
          default: push_start($urandom_range(DEPTH - 1), $urandom_range(0, 63));
        endcase
        n++;
      end else begin
        r = rand_req();
        if (r.req_type == REQ_WRITE) begin
          push_write(r.entry_index, r.on_time, r.off_time);
        end else begin
          pending_req_q.push_back(r);
        end
        n++;
      end
    end
  endtask

  // Request driver: offer the next pending transaction, predict on acceptance
  always @(posedge clk) begin : req_driver
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsp_q.push_back(predict_playback(req));
      end
      if (!req_valid || req_ready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_req_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare each accepted transaction with the oldest prediction
  always @(posedge clk) begin : rsp_monitor
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.buzzer_drive !== want.buzzer_drive) begin
            report_mismatch($sformatf("buzzer_drive got %b want %b",
                                      rsp.buzzer_drive, want.buzzer_drive));
          end
          if (rsp.playing !== want.playing) begin
            report_mismatch($sformatf("playing got %b want %b", rsp.playing, want.playing));
          end
          if (rsp.note_position !== want.note_position) begin
            report_mismatch($sformatf("note_position got %0d want %0d",
                                      rsp.note_position, want.note_position));
          end
        end
      end
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long response hold-off early on, while the driver keeps offering
  initial begin : rsp_hold_off
    while (rst) @(posedge clk);
    repeat (40) @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (stage_no = 0; stage_no < 4; stage_no++) begin
      @(negedge clk);
      case (stage_no)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (stage_no == 0) begin
        // every entry is written before any pattern can read it
        for (int i = 0; i < DEPTH; i++) begin
          push_write(i, $urandom_range(1, 4), $urandom_range(0, 4));
        end
        // extreme durations, a rest note and an all-zero entry
        push_write(0, 16'hFFFF, 16'hFFFF);
        push_write(DEPTH - 1, 0, 3);
        push_write(5, 0, 0);
        push_write(4, 1, 0);
        // pattern wrapping from the top entry to entry 0, rest note first
        push_start(DEPTH - 1, 2);
        repeat (5) push_tick();
        push_stop();
        // tick while idle, zero-count start while idle
        push_tick();
        push_start(5, 0);
        // all-zero first entry still plays; zero count ignored while playing
        push_start(5, 3);
        repeat (2) push_tick();
        push_start(5, 0);
        // restart while playing, oversized count, pattern ends at the all-zero entry
        push_start(4, 63);
        repeat (3) push_tick();
        // write to the playing entry
        push_start(3, 1);
        push_write(3, 2, 1);
        repeat (4) push_tick();
      end
      random_items(ITEMS_STAGE);
      // sender pauses until every response of this stage is in
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0) begin
        @(posedge clk);
      end
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tps_pkg.sv
rtl/tps_ram.sv
rtl/tps_ctrl.sv
rtl/tone_pattern_sequencer.sv
verif/tone_pattern_sequencer_tb.sv
